[hdl/double_hash_table_defines.svh]
// Assertion macros shared by the checker of the double hash table.
// Needs signals named clk and arst_n in the scope where a macro is used.
`ifndef DOUBLE_HASH_TABLE_DEFINES_SVH
`define DOUBLE_HASH_TABLE_DEFINES_SVH

// Check the consequent in the same cycle as the antecedent.
`define DHT_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check the consequent in the cycle after the antecedent.
`define DHT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/dht_pkg.sv]
// Package of the double hash table: opcodes, field widths, slot word and state types.
// No dependencies.
package dht_pkg;

	localparam int KEY_W = 31;
	localparam int MOD_W = 16;
	localparam int PCNT_W = 16;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_FIND = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [MOD_W-1:0] MOD_RESET = 16'd17;

	typedef struct packed {
		logic used;
		logic [KEY_W-1:0] key;
	} slot_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_PROBE,
		ST_HOLD
	} dht_state_t;

	typedef enum logic [1:0] {
		HS_IDLE,
		HS_KEY,
		HS_STEP
	} hash_state_t;

endpackage

[hdl/dht_if.sv]
// Request and response channel interfaces of the double hash table.
// Depends on dht_pkg for the field widths.
interface dht_req_if import dht_pkg::*; ();
	logic valid;
	logic ready;
	logic [1:0] opcode;
	logic [KEY_W-1:0] key;

	modport source(output valid, output opcode, output key, input ready);
	modport sink(input valid, input opcode, input key, output ready);
endinterface

interface dht_rsp_if import dht_pkg::*; ();
	logic valid;
	logic ready;
	logic found;
	logic [PCNT_W-1:0] probe_count;

	modport source(output valid, output found, output probe_count, input ready);
	modport sink(input valid, input found, input probe_count, output ready);
endinterface

[hdl/dht_hash.sv]
// Hash unit: home slot (key mod table size) by reciprocal multiply, and probe step by a
// serial remainder over the step modulus. Depends on dht_pkg.
module dht_hash import dht_pkg::*; #(
	parameter int TABLE_SIZE = 1021,
	localparam int PW = $clog2(TABLE_SIZE)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [KEY_W-1:0] key,
	input  logic [MOD_W-1:0] modulus,
	output logic             done,
	output logic [PW-1:0]    home,
	output logic [PW-1:0]    inc
);

	localparam int RW = PW + 1;
	localparam int CW = $clog2(KEY_W);
	localparam int FOLD_CYCLES = 3;
	localparam logic [RW-1:0] SIZE_R = RW'(TABLE_SIZE);
	localparam logic [KEY_W-1:0] SIZE_K = KEY_W'(TABLE_SIZE);
	// floor(2^KEY_W / TABLE_SIZE): the quotient estimate is exact or one short
	localparam logic [KEY_W-1:0] RECIP = KEY_W'((64'd1 << KEY_W) / TABLE_SIZE);

	hash_state_t state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic done_q;
	logic [KEY_W-1:0] sh_q, red_x_q;
	logic [PW-1:0] home_q, inc_q;
	logic [MOD_W-1:0] rm_q;
	logic [KEY_W-1:0] x_s1, q_s1;
	logic [RW-1:0] rem_s2;

	logic [MOD_W-1:0] m1, rm_d, step;
	logic [MOD_W:0] tm;
	logic [2*KEY_W-1:0] prod;
	logic [KEY_W-1:0] qd, diff;
	logic [PW-1:0] fold;
	logic key_last, step_last;

	// restoring remainder steps: shift in the next bit, subtract once if needed
	always_comb begin
		m1 = (modulus == '0) ? MOD_W'(1) : modulus;
		tm = {rm_q, sh_q[KEY_W-1]};
		rm_d = (tm >= {1'b0, m1}) ? MOD_W'(tm - {1'b0, m1}) : tm[MOD_W-1:0];
		step = m1 - rm_d;
	end

	// reduce by the table size: estimate the quotient, multiply back, correct once
	always_comb begin
		prod = {{KEY_W{1'b0}}, red_x_q} * {{KEY_W{1'b0}}, RECIP};
		qd = q_s1 * SIZE_K;
		diff = x_s1 - qd;
		fold = (rem_s2 >= SIZE_R) ? PW'(rem_s2 - SIZE_R) : rem_s2[PW-1:0];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			HS_IDLE: begin
				if (start) state_d = HS_KEY;
			end
			HS_KEY: begin
				if (cnt_q == '0) state_d = HS_STEP;
			end
			HS_STEP: begin
				if (cnt_q == '0) state_d = HS_IDLE;
			end
			default: state_d = HS_IDLE;
		endcase
	end

	always_comb begin
		key_last = (state_q == HS_KEY) && (cnt_q == '0);
		step_last = (state_q == HS_STEP) && (cnt_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= HS_IDLE;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= step_last;
			if (state_q == HS_IDLE) begin
				cnt_q <= CW'(KEY_W - 1);
			end else if (key_last) begin
				cnt_q <= CW'(FOLD_CYCLES - 1);
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		x_s1 <= red_x_q;
		q_s1 <= prod[2*KEY_W-1:KEY_W];
		rem_s2 <= diff[RW-1:0];
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			HS_KEY: begin
				rm_q <= rm_d;
				sh_q <= sh_q << 1;
				if (key_last) begin
					home_q <= fold;
					red_x_q <= {{(KEY_W - MOD_W){1'b0}}, step};
				end
			end
			HS_STEP: begin
				if (step_last) inc_q <= fold;
			end
			default: begin
				sh_q <= key;
				red_x_q <= key;
				rm_q <= '0;
			end
		endcase
	end

	assign done = done_q;
	assign home = home_q;
	assign inc = inc_q;

endmodule

[hdl/double_hash_table.sv]
// Top level of the double hash table: slot memory, probe sequencer, output register.
// Depends on dht_pkg, dht_if.sv (channel interfaces) and dht_hash.
//
// channel   dir   handshake     payload
// req       in    valid/ready   opcode[1:0], key[30:0]
// rsp       out   valid/ready   found, probe_count[15:0]
// cfg       in    cfg_we        cfg_wdata[15:0] (step modulus)
//
// Insert and find first hash the key (serial remainder by the step modulus, reduction
//   of the step by the table size, a handoff), then take one cycle per probe of the
//   slot memory and go back to ST_IDLE, where the next request can be taken.
// Clear and reset sweep every slot of the memory with req.ready low.
// Ignored requests (full insert, find on an empty table, unused opcode) retire in ST_IDLE.
// A find result waits in the output register; a later result stalls in ST_HOLD until
//   rsp takes the earlier one.
module double_hash_table import dht_pkg::*; #(
	parameter int TABLE_SIZE = 1021
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [MOD_W-1:0] cfg_wdata,
	dht_req_if.sink          req,
	dht_rsp_if.source        rsp
);

	localparam int PW = $clog2(TABLE_SIZE);
	localparam int RW = PW + 1;
	localparam int EW = $clog2(TABLE_SIZE + 1);
	localparam logic [PW-1:0] LAST_SLOT = PW'(TABLE_SIZE - 1);
	localparam logic [RW-1:0] SIZE_R = RW'(TABLE_SIZE);
	localparam logic [EW-1:0] FULL_CNT = EW'(TABLE_SIZE);

	// Slot memory: used flag and key in one word, one read and one write port.
	slot_t mem [TABLE_SIZE];
	slot_t rdata_q;
	slot_t wr_data;
	logic wr_en;
	logic [PW-1:0] wr_addr, rd_addr;

	dht_state_t state_q, state_d;
	logic [MOD_W-1:0] mod_q;
	logic [1:0] op_q;
	logic [KEY_W-1:0] key_q;
	logic [PW-1:0] pos_q, j_q, clr_q;
	logic [EW-1:0] cnt_q;
	logic pend_found_q;
	logic out_valid_q, out_found_q;
	logic [PCNT_W-1:0] out_count_q;

	logic accept, table_full, table_empty, hash_start;
	logic hash_done;
	logic [PW-1:0] hash_home, hash_inc;
	logic hit_empty, hit_key, last_probe, is_find, resolve, out_free;
	logic [RW-1:0] pos_sum;
	logic [PW-1:0] pos_nx;
	logic out_load, out_load_found, probe_adv, cnt_inc, clear_start;

	assign req.ready = (state_q == ST_IDLE);
	assign accept = req.valid && req.ready;
	assign table_full = (cnt_q == FULL_CNT);
	assign table_empty = (cnt_q == '0);

	// Hash only the requests that will probe; the others retire in the idle cycle.
	assign hash_start = accept &&
		(((req.opcode == OP_INSERT) && !table_full) ||
		 ((req.opcode == OP_FIND) && !table_empty));

	dht_hash #(.TABLE_SIZE(TABLE_SIZE)) u_hash (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (hash_start),
		.key     (req.key),
		.modulus (mod_q),
		.done    (hash_done),
		.home    (hash_home),
		.inc     (hash_inc)
	);

	// Probe evaluation on the word read for pos_q in the previous cycle.
	always_comb begin
		hit_empty = !rdata_q.used;
		hit_key = rdata_q.used && (rdata_q.key == key_q);
		last_probe = (j_q == LAST_SLOT);
		is_find = (op_q == OP_FIND);
		resolve = is_find ? (hit_empty || hit_key) : hit_empty;
		out_free = !out_valid_q || rsp.ready;
		pos_sum = {1'b0, pos_q} + {1'b0, hash_inc};
		pos_nx = (pos_sum >= SIZE_R) ? PW'(pos_sum - SIZE_R) : pos_sum[PW-1:0];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == LAST_SLOT) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept && (req.opcode == OP_CLEAR)) begin
					state_d = ST_CLEAR;
				end else if (hash_start) begin
					state_d = ST_HASH;
				end
			end
			ST_HASH: begin
				if (hash_done) state_d = ST_PROBE;
			end
			ST_PROBE: begin
				priority if (resolve) begin
					state_d = (is_find && !out_free) ? ST_HOLD : ST_IDLE;
				end else if (last_probe) begin
					state_d = ST_IDLE;
				end
			end
			ST_HOLD: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// Memory port and datapath controls.
	always_comb begin
		rd_addr = (state_q == ST_HASH) ? hash_home : pos_nx;
		wr_en = 1'b0;
		wr_addr = clr_q;
		wr_data = '0;
		out_load = 1'b0;
		out_load_found = pend_found_q;
		probe_adv = 1'b0;
		cnt_inc = 1'b0;
		clear_start = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				wr_en = 1'b1;
			end
			ST_IDLE: begin
				clear_start = accept && (req.opcode == OP_CLEAR);
			end
			ST_PROBE: begin
				if (!is_find && hit_empty) begin
					// claim the first unused slot of the sequence
					wr_en = 1'b1;
					wr_addr = pos_q;
					wr_data = '{used: 1'b1, key: key_q};
					cnt_inc = 1'b1;
				end
				out_load = is_find && resolve && out_free;
				out_load_found = hit_key;
				probe_adv = !resolve && !last_probe;
			end
			ST_HOLD: begin
				out_load = out_free;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// Writes happen only when a sequence ends or during the sweep, and the next read
	// of the same slot comes after a full hash pass, so no forwarding is needed.
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			mod_q <= MOD_RESET;
			clr_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) mod_q <= cfg_wdata;
			if (clear_start) begin
				clr_q <= '0;
			end else if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (clear_start) begin
				cnt_q <= '0;
			end else if (cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: request, probe position, pending and delivered result.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= req.opcode;
			key_q <= req.key;
		end
		if (state_q == ST_HASH) begin
			pos_q <= hash_home;
			j_q <= '0;
		end else if (probe_adv) begin
			pos_q <= pos_nx;
			j_q <= j_q + 1'b1;
		end
		if (state_q == ST_PROBE) pend_found_q <= hit_key;
		if (out_load) begin
			out_found_q <= out_load_found;
			out_count_q <= PCNT_W'(j_q) + PCNT_W'(1);
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.found = out_found_q;
	assign rsp.probe_count = out_count_q;

endmodule

[hdl/dht_checker.sv]
// Port-level checker of the double hash table and its bind to the top level.
// Depends on dht_pkg and double_hash_table_defines.svh.
`include "double_hash_table_defines.svh"

module dht_checker import dht_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic [1:0]        req_opcode,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic              rsp_found,
	input logic [PCNT_W-1:0] rsp_probe_count
);

	// a stalled response holds its payload
	`DHT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_found) && $stable(rsp_probe_count), "rsp changed while stalled")

	// every find examines at least one slot
	`DHT_ASSERT_SAME(a_probe_nonzero, rsp_valid, rsp_probe_count != '0, "probe_count is zero")

	// clear starts the memory sweep and drops ready
	`DHT_ASSERT_NEXT(a_clear_busy, req_valid && req_ready && (req_opcode == OP_CLEAR), !req_ready, "ready high after clear")

	// no result can appear the cycle after a request is taken
	`DHT_ASSERT_NEXT(a_no_instant_rsp, req_valid && req_ready, !(rsp_valid && !$past(rsp_valid)), "response right after request")

endmodule

bind double_hash_table dht_checker u_dht_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.req_opcode      (req.opcode),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_found       (rsp.found),
	.rsp_probe_count (rsp.probe_count)
);

[dv/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for double_hash_table: queued insert/find/clear requests, an
// in-bench hash table predictor and in-order checking of every find result.
// Depends on dht_pkg, dht_if.sv and the double_hash_table RTL.
module testbench;
	import dht_pkg::*;

	localparam int TABLE_SLOTS = 1021;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [KEY_W-1:0] KEY_MAX = '1;
	// Worst single request: hashing plus a probe of every slot, or a sweep.
	localparam int SETTLE_CYCLES = 1500;
	localparam int LONG_STALL = 600;
	localparam int QUIET_LIMIT = 20000;

	typedef struct packed {
		logic [1:0] opcode;
		logic [KEY_W-1:0] key;
	} request_t;

	typedef struct packed {
		logic found;
		logic [PCNT_W-1:0] probe_count;
	} lookup_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [MOD_W-1:0] cfg_wdata;

	dht_req_if req();
	dht_rsp_if rsp();

	double_hash_table #(.TABLE_SIZE(TABLE_SLOTS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.req(req),
		.rsp(rsp)
	);

	// Requests waiting to be offered, and find results the table still owes us.
	request_t req_backlog[$];
	lookup_t lookups_due[$];
	// Keys inserted since the last clear; used to aim finds at stored keys.
	logic [KEY_W-1:0] live_keys[$];

	// Predictor state: our own copy of the table and of the step modulus.
	logic [KEY_W-1:0] slot_key[TABLE_SLOTS];
	bit slot_taken[TABLE_SLOTS];
	int unsigned slot_fill = 0;
	logic [MOD_W-1:0] step_mod = MOD_RESET;

	bit idling_on = 1'b1;
	int send_gap = 0;
	int sink_gap = 0;
	int stall_left = 0;
	int results_seen = 0;
	int errors = 0;
	int quiet_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Advance the predictor by one accepted request. Returns 1 when the request yields a
	// find result, which is then placed in outcome.
	function automatic bit apply_request(input request_t rq, output lookup_t outcome);
		int unsigned k;
		int unsigned m;
		int unsigned pos;
		int unsigned inc;
		outcome = '0;
		if (rq.opcode == OP_CLEAR) begin
			foreach (slot_taken[i])
				slot_taken[i] = 1'b0;
			slot_fill = 0;
			return 1'b0;
		end
		if (rq.opcode != OP_INSERT && rq.opcode != OP_FIND)
			return 1'b0;
		k = {1'b0, rq.key};
		// A zero modulus behaves as one, giving a step of one.
		m = (step_mod == '0) ? 1 : {16'd0, step_mod};
		pos = k % TABLE_SLOTS;
		inc = (m - (k % m)) % TABLE_SLOTS;
		if (rq.opcode == OP_INSERT) begin
			if (slot_fill >= TABLE_SLOTS)
				return 1'b0;
			for (int j = 0; j < TABLE_SLOTS; j++) begin
				if (!slot_taken[pos]) begin
					slot_taken[pos] = 1'b1;
					slot_key[pos] = rq.key;
					slot_fill++;
					return 1'b0;
				end
				pos = (pos + inc) % TABLE_SLOTS;
			end
			// No free slot on the whole sequence: drop the insert.
			return 1'b0;
		end
		if (slot_fill == 0)
			return 1'b0;
		for (int j = 0; j < TABLE_SLOTS; j++) begin
			if (!slot_taken[pos] || slot_key[pos] == rq.key) begin
				outcome.found = slot_taken[pos];
				outcome.probe_count = PCNT_W'(j + 1);
				return 1'b1;
			end
			pos = (pos + inc) % TABLE_SLOTS;
		end
		// Full sequence probed with neither a hit nor a hole: no result.
		return 1'b0;
	endfunction

	// Mix of colliding keys (shared home slot), full-range keys and the extremes.
	function automatic logic [KEY_W-1:0] pick_key();
		int roll;
		logic [31:0] raw;
		roll = $urandom_range(0, 19);
		raw = $urandom();
		if (roll < 10)
			return KEY_W'(TABLE_SLOTS * $urandom_range(0, 40) + $urandom_range(0, 7));
		else if (roll < 17)
			return raw[KEY_W-1:0];
		else if (roll == 17)
			return '0;
		else if (roll == 18)
			return KEY_MAX;
		else
			return KEY_MAX - KEY_W'($urandom_range(0, 3));
	endfunction

	task automatic queue_request(input logic [1:0] opcode, input logic [KEY_W-1:0] key);
		request_t rq;
		rq.opcode = opcode;
		rq.key = key;
		req_backlog.push_back(rq);
		if (opcode == OP_INSERT)
			live_keys.push_back(key);
		else if (opcode == OP_CLEAR)
			live_keys.delete();
	endtask

	// Mostly inserts followed by finds of stored keys; misses, clears and the
	// unused opcode make up the rest.
	task automatic random_mix(input int count);
		int roll;
		logic [KEY_W-1:0] k;
		repeat (count) begin
			roll = $urandom_range(0, 99);
			if (roll < 45) begin
				queue_request(OP_INSERT, pick_key());
			end else if (roll < 90) begin
				if (live_keys.size() != 0 && $urandom_range(0, 2) != 0)
					k = live_keys[$urandom_range(0, live_keys.size() - 1)];
				else
					k = pick_key();
				queue_request(OP_FIND, k);
			end else if (roll < 95) begin
				queue_request(OP_CLEAR, pick_key());
			end else begin
				queue_request(OP_UNUSED, pick_key());
			end
		end
	endtask

	// Hold until every request is taken and every result is back, then give a request
	// that yields no result time to finish before the caller touches the register.
	task automatic drain();
		do
			@(posedge clk);
		while (req_backlog.size() != 0 || req.valid || lookups_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_step(input logic [MOD_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		step_mod = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Request driver: offer the next queued request, predicting each one as it is taken.
	always @(posedge clk) begin
		request_t taken;
		request_t next_rq;
		lookup_t outcome;
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.opcode <= OP_INSERT;
			req.key <= '0;
		end else begin
			if (req.valid && req.ready) begin
				taken.opcode = req.opcode;
				taken.key = req.key;
				if (apply_request(taken, outcome))
					lookups_due.push_back(outcome);
				if (idling_on && $urandom_range(0, 4) == 0)
					send_gap = $urandom_range(1, 7);
			end
			if (!req.valid || req.ready) begin
				if (send_gap != 0) begin
					send_gap--;
					req.valid <= 1'b0;
				end else if (req_backlog.size() != 0) begin
					next_rq = req_backlog.pop_front();
					req.valid <= 1'b1;
					req.opcode <= next_rq.opcode;
					req.key <= next_rq.key;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: check each result against the oldest prediction, and pace rsp.ready.
	always @(posedge clk) begin
		lookup_t want;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				results_seen++;
				if (lookups_due.size() == 0) begin
					$error("unexpected result: found %0d, probe_count %0d", rsp.found,
						rsp.probe_count);
					errors++;
				end else begin
					want = lookups_due.pop_front();
					if (rsp.found !== want.found) begin
						$error("found: expected %0d, got %0d", want.found, rsp.found);
						errors++;
					end
					if (rsp.probe_count !== want.probe_count) begin
						$error("probe_count: expected %0d, got %0d", want.probe_count,
							rsp.probe_count);
						errors++;
					end
				end
				// Long hold-off: the sender keeps offering, so the table backs up and
				// has to drop req.ready.
				if (idling_on && (results_seen == 60 || results_seen == 250))
					stall_left = LONG_STALL;
			end
			if (stall_left != 0) begin
				stall_left--;
				rsp.ready <= 1'b0;
			end else if (sink_gap != 0) begin
				sink_gap--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
				if (idling_on && $urandom_range(0, 5) == 0)
					sink_gap = $urandom_range(1, 7);
			end
		end
	end

	// Watchdog: end the run if nothing moves on either channel for too long.
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed pass at the reset modulus: empty-table find, extremes, a chain on
		// home slot zero, a duplicate insert, the unused opcode and a clear.
		queue_request(OP_FIND, KEY_W'(5));
		queue_request(OP_INSERT, '0);
		queue_request(OP_INSERT, KEY_MAX);
		queue_request(OP_INSERT, KEY_W'(TABLE_SLOTS));
		queue_request(OP_INSERT, '0);
		queue_request(OP_INSERT, KEY_W'(2 * TABLE_SLOTS));
		queue_request(OP_FIND, '0);
		queue_request(OP_FIND, KEY_W'(TABLE_SLOTS));
		queue_request(OP_FIND, KEY_W'(2 * TABLE_SLOTS));
		queue_request(OP_FIND, KEY_MAX);
		queue_request(OP_FIND, KEY_W'(3 * TABLE_SLOTS));
		queue_request(OP_FIND, KEY_W'(12345));
		queue_request(OP_UNUSED, KEY_MAX);
		queue_request(OP_UNUSED, '0);
		queue_request(OP_FIND, KEY_MAX - 1'b1);
		queue_request(OP_CLEAR, '0);
		queue_request(OP_FIND, '0);
		queue_request(OP_INSERT, KEY_W'(1));
		queue_request(OP_FIND, KEY_W'(1));
		queue_request(OP_FIND, KEY_W'(TABLE_SLOTS + 1));
		drain();

		// Modulus twice the table size: these keys get a zero step and never leave the home
		// slot, so an insert onto a taken home is dropped and a miss there yields nothing.
		write_step(16'd2042);
		queue_request(OP_CLEAR, '0);
		queue_request(OP_INSERT, KEY_W'(TABLE_SLOTS));
		queue_request(OP_INSERT, KEY_W'(3 * TABLE_SLOTS));
		queue_request(OP_FIND, KEY_W'(3 * TABLE_SLOTS));
		queue_request(OP_FIND, KEY_W'(TABLE_SLOTS));
		queue_request(OP_FIND, KEY_W'(5 * TABLE_SLOTS));
		random_mix(80);
		drain();

		// Zero modulus: plain linear probing.
		write_step(16'd0);
		random_mix(100);
		drain();

		write_step(16'd65521);
		random_mix(150);
		drain();

		// Fill every slot. A modulus below the table size never gives a zero step, so
		// each insert lands; then try inserts on the full table and finds that probe
		// the whole sequence.
		write_step(16'd1019);
		queue_request(OP_CLEAR, '0);
		repeat (TABLE_SLOTS + 2) queue_request(OP_INSERT, pick_key());
		repeat (20) queue_request(OP_FIND, live_keys[$urandom_range(0, live_keys.size() - 1)]);
		repeat (15) queue_request(OP_FIND, pick_key());
		drain();

		write_step(16'd2);
		queue_request(OP_CLEAR, '0);
		random_mix(120);
		drain();

		write_step(MOD_W'($urandom_range(2, 65519)) | 16'd4);
		random_mix(100);
		drain();

		write_step(16'd1);
		random_mix(60);
		drain();

		// Last stretch runs flat out on both sides.
		write_step(MOD_RESET);
		idling_on = 1'b0;
		random_mix(100);
		drain();

		if (errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

[files.f]
+incdir+hdl
hdl/dht_pkg.sv
hdl/dht_if.sv
hdl/dht_hash.sv
hdl/double_hash_table.sv
hdl/dht_checker.sv
dv/testbench.sv
